// ===== design/uqps_pkg.sv =====
// Shared constants, command codes and status type for the URL query parameter sorter.
package uqps_pkg;

    localparam int DEF_MAX_LEN    = 512;
    localparam int DEF_MAX_PARAMS = 64;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;

    localparam logic [1:0] ST_SORTED = 2'd0;
    localparam logic [1:0] ST_PLAIN  = 2'd1;
    localparam logic [1:0] ST_OVER   = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    typedef logic [4:0] cmd_t;

    localparam cmd_t OP_NOP    = 5'd0;
    localparam cmd_t OP_LOAD   = 5'd1;
    localparam cmd_t OP_FIN    = 5'd2;
    localparam cmd_t OP_SINIT  = 5'd3;
    localparam cmd_t OP_OUTER  = 5'd4;
    localparam cmd_t OP_VCAP   = 5'd5;
    localparam cmd_t OP_WRD    = 5'd6;
    localparam cmd_t OP_WCAP   = 5'd7;
    localparam cmd_t OP_WTB    = 5'd8;
    localparam cmd_t OP_CRD    = 5'd9;
    localparam cmd_t OP_CSTEP  = 5'd10;
    localparam cmd_t OP_SHIFT  = 5'd11;
    localparam cmd_t OP_PLACE  = 5'd12;
    localparam cmd_t OP_ESTART = 5'd13;
    localparam cmd_t OP_BRD    = 5'd14;
    localparam cmd_t OP_BWR    = 5'd15;
    localparam cmd_t OP_AMP    = 5'd16;
    localparam cmd_t OP_FLUSH  = 5'd17;
    localparam cmd_t OP_PRD    = 5'd18;
    localparam cmd_t OP_PTB    = 5'd19;
    localparam cmd_t OP_PCHK   = 5'd20;

    typedef struct packed {
        logic sort_ok;
        logic i_eq_n;
        logic j_zero;
        logic k_end;
        logic c_eq;
        logic c_less;
        logic acc_will_full;
        logic will_done;
        logic ptr_will_end;
        logic ptr_lt_end;
        logic done;
        logic tbl_nonempty;
        logic first;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/uqps_dp.sv =====
// Datapath: character store, parameter table, sort order memory, packer and output beat.
module uqps_dp import uqps_pkg::*; #(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  logic [7:0]  s_url_byte,
    input  logic        m_ready,
    output dp_stat_t    stat,
    output logic [63:0] m_out_word,
    output logic [3:0]  m_byte_count,
    output logic        m_last_word,
    output logic [1:0]  m_status,
    output logic        m_valid
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int PIW = $clog2(MAX_PARAMS);
    localparam int PCW = $clog2(MAX_PARAMS + 1);
    localparam int TW  = 2 * CW;

    logic [7:0]    char_mem [MAX_LEN];
    logic [TW-1:0] tbl_mem  [MAX_PARAMS];
    logic [PIW-1:0] ord_mem [MAX_PARAMS];

    logic [7:0]     rda_reg, rdb_reg;
    logic [TW-1:0]  tbl_rd_reg;
    logic [PIW-1:0] ord_rd_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] qs_reg, qs_next;
    logic          trunc_reg, trunc_next;
    logic          prev_amp_reg, prev_amp_next;
    logic [CW-1:0] runs_reg, runs_next;
    logic [CW-1:0] ampc_reg, ampc_next;
    logic [CW-1:0] nonempty_reg, nonempty_next;
    logic [CW-1:0] cur_begin_reg, cur_begin_next;
    logic [PCW-1:0] n_reg, n_next;
    logic [CW-1:0] olen_reg, olen_next;
    logic [1:0]    status_reg, status_next;
    logic [PCW-1:0] i_reg, i_next;
    logic [PIW-1:0] j_reg, j_next;
    logic [PIW-1:0] v_reg, v_next;
    logic [PIW-1:0] w_reg, w_next;
    logic [CW-1:0] vb_reg, vb_next;
    logic [CW-1:0] ve_reg, ve_next;
    logic [CW-1:0] wb_reg, wb_next;
    logic [CW-1:0] minlen_reg, minlen_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] seg_end_reg, seg_end_next;
    logic [CW-1:0] emitted_reg, emitted_next;
    logic          first_reg, first_next;
    logic [63:0]   acc_reg, acc_next;
    logic [3:0]    acnt_reg, acnt_next;
    logic [63:0]   mword_reg, mword_next;
    logic [3:0]    mcnt_reg, mcnt_next;
    logic          mlast_reg, mlast_next;
    logic [1:0]    mstat_reg, mstat_next;
    logic          mvalid_reg, mvalid_next;

    logic [CW-1:0] tbl_b, tbl_e, lv, lw;
    logic [CW-1:0] kf;
    logic [1:0]    decide;
    logic          runs_fit;
    logic [AW-1:0] addr_a, addr_b;
    logic [PIW-1:0] tbl_raddr, ord_raddr;
    logic          char_we, tbl_we, ord_we;
    logic [AW-1:0] char_waddr;
    logic [PIW-1:0] tbl_waddr, ord_waddr;
    logic [TW-1:0] tbl_wdata;
    logic [PIW-1:0] ord_wdata;
    logic [7:0]    acc_byte;

    assign tbl_b    = tbl_rd_reg[TW-1:CW];
    assign tbl_e    = tbl_rd_reg[CW-1:0];
    assign lv       = ve_reg - vb_reg;
    assign lw       = tbl_e - tbl_b;
    assign runs_fit = 32'(runs_reg) < MAX_PARAMS;
    assign kf       = nonempty_reg + CW'(count_reg > cur_begin_reg);

    always_comb begin
        priority if (trunc_reg) begin
            decide = ST_TRUNC;
        end else if (qs_reg == '0 || ampc_reg == '0) begin
            decide = ST_PLAIN;
        end else if (!runs_fit) begin
            decide = ST_OVER;
        end else begin
            decide = ST_SORTED;
        end
    end

    assign addr_a    = (cmd == OP_CRD) ? AW'(vb_reg + k_reg) : ptr_reg[AW-1:0];
    assign addr_b    = AW'(wb_reg + k_reg);
    assign tbl_raddr = (cmd == OP_OUTER) ? i_reg[PIW-1:0] : ord_rd_reg;
    assign ord_raddr = (cmd == OP_WRD) ? PIW'(j_reg - 1'b1) : i_reg[PIW-1:0];

    always_ff @(posedge aclk) begin
        if (char_we) begin
            char_mem[char_waddr] <= s_url_byte;
        end
        rda_reg <= char_mem[addr_a];
        rdb_reg <= char_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    always_comb begin
        count_next     = count_reg;
        qs_next        = qs_reg;
        trunc_next     = trunc_reg;
        prev_amp_next  = prev_amp_reg;
        runs_next      = runs_reg;
        ampc_next      = ampc_reg;
        nonempty_next  = nonempty_reg;
        cur_begin_next = cur_begin_reg;
        n_next         = n_reg;
        olen_next      = olen_reg;
        status_next    = status_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        vb_next        = vb_reg;
        ve_next        = ve_reg;
        wb_next        = wb_reg;
        minlen_next    = minlen_reg;
        k_next         = k_reg;
        ptr_next       = ptr_reg;
        seg_end_next   = seg_end_reg;
        emitted_next   = emitted_reg;
        first_next     = first_reg;
        acc_next       = acc_reg;
        acnt_next      = acnt_reg;
        mword_next     = mword_reg;
        mcnt_next      = mcnt_reg;
        mlast_next     = mlast_reg;
        mstat_next     = mstat_reg;
        mvalid_next    = mvalid_reg && !m_ready;
        char_we        = 1'b0;
        char_waddr     = count_reg[AW-1:0];
        tbl_we         = 1'b0;
        tbl_waddr      = runs_reg[PIW-1:0];
        tbl_wdata      = {cur_begin_reg, count_reg};
        ord_we         = 1'b0;
        ord_waddr      = j_reg;
        ord_wdata      = v_reg;
        acc_byte       = (cmd == OP_AMP) ? CH_AMP : rda_reg;

        unique case (cmd)
            OP_LOAD: begin
                if (count_reg < CW'(MAX_LEN)) begin
                    char_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                    prev_amp_next = 1'b0;
                    if (s_url_byte == CH_QMARK && qs_reg == '0) begin
                        qs_next        = count_reg + 1'b1;
                        cur_begin_next = count_reg + 1'b1;
                    end else if (s_url_byte == CH_AMP && qs_reg != '0) begin
                        ampc_next      = ampc_reg + 1'b1;
                        cur_begin_next = count_reg + 1'b1;
                        prev_amp_next  = 1'b1;
                        if (!prev_amp_reg) begin
                            runs_next = runs_reg + 1'b1;
                            tbl_we    = runs_fit;
                            if (count_reg > cur_begin_reg) begin
                                nonempty_next = nonempty_reg + 1'b1;
                            end
                        end
                    end
                end else begin
                    trunc_next = 1'b1;
                end
            end
            OP_FIN: begin
                tbl_we      = runs_fit;
                n_next      = PCW'(runs_reg + 1'b1);
                status_next = decide;
                if (decide == ST_SORTED) begin
                    olen_next = count_reg - ampc_reg + kf - CW'(kf != '0);
                end else begin
                    olen_next = count_reg;
                end
            end
            OP_SINIT: begin
                ord_we    = 1'b1;
                ord_waddr = '0;
                ord_wdata = '0;
                i_next    = PCW'(1);
            end
            OP_OUTER: begin
                v_next = i_reg[PIW-1:0];
                j_next = i_reg[PIW-1:0];
            end
            OP_VCAP: begin
                vb_next = tbl_b;
                ve_next = tbl_e;
            end
            OP_WCAP: begin
                w_next = ord_rd_reg;
            end
            OP_WTB: begin
                wb_next     = tbl_b;
                minlen_next = (lv < lw) ? lv : lw;
                k_next      = '0;
            end
            OP_CSTEP: begin
                k_next = k_reg + 1'b1;
            end
            OP_SHIFT: begin
                ord_we    = 1'b1;
                ord_wdata = w_reg;
                j_next    = j_reg - 1'b1;
            end
            OP_PLACE: begin
                ord_we = 1'b1;
                i_next = i_reg + 1'b1;
            end
            OP_ESTART: begin
                ptr_next     = '0;
                seg_end_next = (status_reg == ST_SORTED) ? qs_reg : count_reg;
                emitted_next = '0;
                acc_next     = '0;
                acnt_next    = '0;
                first_next   = 1'b1;
                i_next       = '0;
            end
            OP_BWR, OP_AMP: begin
                acc_next[{acnt_reg[2:0], 3'b000} +: 8] = acc_byte;
                acnt_next    = acnt_reg + 1'b1;
                emitted_next = emitted_reg + 1'b1;
                if (cmd == OP_BWR) begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            OP_FLUSH: begin
                mword_next  = acc_reg;
                mcnt_next   = acnt_reg;
                mlast_next  = (emitted_reg == olen_reg);
                mstat_next  = status_reg;
                mvalid_next = 1'b1;
                acc_next    = '0;
                acnt_next   = '0;
                if (emitted_reg == olen_reg) begin
                    count_next    = '0;
                    qs_next       = '0;
                    trunc_next    = 1'b0;
                    prev_amp_next = 1'b0;
                    runs_next     = '0;
                    ampc_next     = '0;
                    nonempty_next = '0;
                end
            end
            OP_PCHK: begin
                i_next = i_reg + 1'b1;
                if (tbl_e > tbl_b) begin
                    ptr_next     = tbl_b;
                    seg_end_next = tbl_e;
                    first_next   = 1'b0;
                end
            end
            OP_NOP, OP_WRD, OP_CRD, OP_BRD, OP_PRD, OP_PTB: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            qs_reg       <= '0;
            trunc_reg    <= 1'b0;
            prev_amp_reg <= 1'b0;
            runs_reg     <= '0;
            ampc_reg     <= '0;
            nonempty_reg <= '0;
            mvalid_reg   <= 1'b0;
            acnt_reg     <= '0;
            acc_reg      <= '0;
        end else begin
            count_reg    <= count_next;
            qs_reg       <= qs_next;
            trunc_reg    <= trunc_next;
            prev_amp_reg <= prev_amp_next;
            runs_reg     <= runs_next;
            ampc_reg     <= ampc_next;
            nonempty_reg <= nonempty_next;
            mvalid_reg   <= mvalid_next;
            acnt_reg     <= acnt_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_begin_reg <= cur_begin_next;
        n_reg         <= n_next;
        olen_reg      <= olen_next;
        status_reg    <= status_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        v_reg         <= v_next;
        w_reg         <= w_next;
        vb_reg        <= vb_next;
        ve_reg        <= ve_next;
        wb_reg        <= wb_next;
        minlen_reg    <= minlen_next;
        k_reg         <= k_next;
        ptr_reg       <= ptr_next;
        seg_end_reg   <= seg_end_next;
        emitted_reg   <= emitted_next;
        first_reg     <= first_next;
        mword_reg     <= mword_next;
        mcnt_reg      <= mcnt_next;
        mlast_reg     <= mlast_next;
        mstat_reg     <= mstat_next;
    end

    assign stat.sort_ok       = (decide == ST_SORTED);
    assign stat.i_eq_n        = (i_reg == n_reg);
    assign stat.j_zero        = (j_reg == '0);
    assign stat.k_end         = (k_reg == minlen_reg);
    assign stat.c_eq          = (rda_reg == rdb_reg);
    assign stat.c_less        = ($signed(rda_reg) < $signed(rdb_reg));
    assign stat.acc_will_full = (acnt_reg == 4'd7);
    assign stat.will_done     = (CW'(emitted_reg + 1'b1) == olen_reg);
    assign stat.ptr_will_end  = !(CW'(ptr_reg + 1'b1) < seg_end_reg);
    assign stat.ptr_lt_end    = (ptr_reg < seg_end_reg);
    assign stat.done          = (emitted_reg == olen_reg);
    assign stat.tbl_nonempty  = (tbl_e > tbl_b);
    assign stat.first         = first_reg;
    assign stat.out_free      = !mvalid_reg || m_ready;

    assign m_out_word   = mword_reg;
    assign m_byte_count = mcnt_reg;
    assign m_last_word  = mlast_reg;
    assign m_status     = mstat_reg;
    assign m_valid      = mvalid_reg;

endmodule

// ===== design/uqps_ctrl.sv =====
// Controller: sequences load, insertion sort and emit through datapath commands.
module uqps_ctrl import uqps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last_byte,
    input  dp_stat_t stat,
    output cmd_t     cmd,
    output logic     s_ready
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FIN    = 5'd1;
    localparam logic [4:0] S_SINIT  = 5'd2;
    localparam logic [4:0] S_OUTER  = 5'd3;
    localparam logic [4:0] S_VCAP   = 5'd4;
    localparam logic [4:0] S_INNER  = 5'd5;
    localparam logic [4:0] S_WCAP   = 5'd6;
    localparam logic [4:0] S_WTB    = 5'd7;
    localparam logic [4:0] S_CRD    = 5'd8;
    localparam logic [4:0] S_CMP    = 5'd9;
    localparam logic [4:0] S_PLACE  = 5'd10;
    localparam logic [4:0] S_ESTART = 5'd11;
    localparam logic [4:0] S_BRD    = 5'd12;
    localparam logic [4:0] S_BWR    = 5'd13;
    localparam logic [4:0] S_AMP    = 5'd14;
    localparam logic [4:0] S_FLUSH  = 5'd15;
    localparam logic [4:0] S_PRD    = 5'd16;
    localparam logic [4:0] S_PTB    = 5'd17;
    localparam logic [4:0] S_PCHK   = 5'd18;

    logic [4:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = OP_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd = OP_LOAD;
                    if (s_last_byte) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                cmd        = OP_FIN;
                state_next = stat.sort_ok ? S_SINIT : S_ESTART;
            end
            S_SINIT: begin
                cmd        = OP_SINIT;
                state_next = S_OUTER;
            end
            S_OUTER: begin
                if (stat.i_eq_n) begin
                    state_next = S_ESTART;
                end else begin
                    cmd        = OP_OUTER;
                    state_next = S_VCAP;
                end
            end
            S_VCAP: begin
                cmd        = OP_VCAP;
                state_next = S_INNER;
            end
            S_INNER: begin
                if (stat.j_zero) begin
                    state_next = S_PLACE;
                end else begin
                    cmd        = OP_WRD;
                    state_next = S_WCAP;
                end
            end
            S_WCAP: begin
                cmd        = OP_WCAP;
                state_next = S_WTB;
            end
            S_WTB: begin
                cmd        = OP_WTB;
                state_next = S_CRD;
            end
            S_CRD: begin
                if (stat.k_end) begin
                    state_next = S_PLACE;
                end else begin
                    cmd        = OP_CRD;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                priority if (stat.c_eq) begin
                    cmd        = OP_CSTEP;
                    state_next = S_CRD;
                end else if (stat.c_less) begin
                    cmd        = OP_SHIFT;
                    state_next = S_INNER;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd        = OP_PLACE;
                state_next = S_OUTER;
            end
            S_ESTART: begin
                cmd        = OP_ESTART;
                state_next = S_BRD;
            end
            S_BRD: begin
                cmd        = OP_BRD;
                state_next = S_BWR;
            end
            S_BWR: begin
                cmd = OP_BWR;
                priority if (stat.acc_will_full || stat.will_done) begin
                    state_next = S_FLUSH;
                end else if (!stat.ptr_will_end) begin
                    state_next = S_BRD;
                end else begin
                    state_next = S_PRD;
                end
            end
            S_AMP: begin
                cmd        = OP_AMP;
                state_next = stat.acc_will_full ? S_FLUSH : S_BRD;
            end
            S_FLUSH: begin
                if (stat.out_free) begin
                    cmd = OP_FLUSH;
                    priority if (stat.done) begin
                        state_next = S_IDLE;
                    end else if (stat.ptr_lt_end) begin
                        state_next = S_BRD;
                    end else begin
                        state_next = S_PRD;
                    end
                end
            end
            S_PRD: begin
                cmd        = OP_PRD;
                state_next = S_PTB;
            end
            S_PTB: begin
                cmd        = OP_PTB;
                state_next = S_PCHK;
            end
            S_PCHK: begin
                cmd = OP_PCHK;
                if (stat.tbl_nonempty) begin
                    state_next = stat.first ? S_BRD : S_AMP;
                end else begin
                    state_next = S_PRD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

// ===== design/url_query_param_sorter_core.sv =====
// URL query parameter sorter: accepts a URL bytewise and emits the sorted URL in 8-byte beats.
// Input channel s_*: one URL byte per beat, s_last_byte on the final byte. A byte is taken
// every cycle while s_ready is high; after the final byte s_ready drops until the whole
// result has been handed to the output register.
// Output channel m_*: up to eight bytes per beat, first byte in the low lane, unused lanes
// zero, m_last_word on the final beat, m_status identical on all beats of one URL.
// After the final byte the FIN state closes the parameter table, then the insertion sort
// runs: its inner compare reads one byte of each parameter at a time (CRD, CMP), each step
// does table lookups (WRD, WCAP, WTB), and each outer pass adds OUTER, VCAP and PLACE. The
// emit pass reads and writes each byte (BRD, BWR), writes each separator (AMP), flushes
// each beat (FLUSH) and looks up each parameter (PRD, PTB, PCHK). Sort and emit walk the
// single character store, which sets the rate.
// Reset clears the load counters, the controller and the output valid; the memories keep
// their contents and need no clearing pass.
// A stalled receiver holds the output register; the emitter waits on it and takes no input.
module url_query_param_sorter_core import uqps_pkg::*; #(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_url_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_word,
    output logic [3:0]  m_byte_count,
    output logic        m_last_word,
    output logic [1:0]  m_status
);

    cmd_t     cmd;
    dp_stat_t stat;

    uqps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .stat        (stat),
        .cmd         (cmd),
        .s_ready     (s_ready)
    );

    uqps_dp #(
        .MAX_LEN    (MAX_LEN),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_url_byte   (s_url_byte),
        .m_ready      (m_ready),
        .stat         (stat),
        .m_out_word   (m_out_word),
        .m_byte_count (m_byte_count),
        .m_last_word  (m_last_word),
        .m_status     (m_status),
        .m_valid      (m_valid)
    );

endmodule

// ===== design/uqps_chk.sv =====
// Port checker for the URL query parameter sorter, bound to the top level.
module uqps_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_url_byte,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_out_word,
    input logic [3:0]  m_byte_count,
    input logic        m_last_word,
    input logic [1:0]  m_status
);

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_count != 4'd0 && m_byte_count <= 4'd8))
        else $error("beat byte count out of range");

    a_full_mid_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_word) |-> (m_byte_count == 4'd8))
        else $error("non-final beat not full");

    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_word) && $stable(m_status)))
        else $error("stalled beat changed");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_byte) |=> !s_ready)
        else $error("input taken right after final byte");

endmodule

bind url_query_param_sorter_core uqps_chk u_uqps_chk (.*);
